// File: rtl/pscs_pkg.sv
package pscs_pkg;

  // Field widths of the point and split words.
  localparam int COORD_W = 32;
  localparam int CE_W    = 31;
  localparam int ANGLE_W = 16;
  localparam int NODE_W  = 16;
  localparam int THR_W   = 16;

  // Longest line that is evaluated, and the number of CORDIC rotations.
  localparam int MAX_POINTS   = 65536;
  localparam int CORDIC_STEPS = 16;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = $clog2(MAX_POINTS);

  // Segment arithmetic.
  localparam int DIFF_W   = COORD_W + 1;
  localparam int MAG_W    = COORD_W;
  localparam int HALF_W   = MAG_W / 2;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int CESQ_W   = 2 * CE_W;
  localparam int NORM_BIT = 40;
  localparam int CW       = NORM_BIT + 5;
  localparam int SHIFT_W  = $clog2(NORM_BIT + 1);
  localparam int MSB_W    = $clog2(MAG_W);
  localparam int Z_W      = 32;

  localparam logic [Z_W-1:0]     Z_HALF_TURN = 32'h8000_0000;
  localparam logic [Z_W-1:0]     ROUND_BIAS  = 32'h0000_8000;
  localparam logic [ANGLE_W-1:0] HALF_TURN   = 16'h8000;
  localparam logic [THR_W-1:0]   THR_RESET   = 16'd8192;

  // Accept-to-queue latency and the depth of the result queue that covers it.
  localparam int PIPE_LATENCY = CORDIC_STEPS + 6;
  localparam int FIFO_AW      = $clog2(PIPE_LATENCY + 2);

  // Register port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_SEL_W  = APB_ADDR_W - 2;
  localparam logic [REG_SEL_W-1:0] REG_CORNER_THRESHOLD = '0;

  // atan(2^-i) with 2^32 units per full turn.
  localparam logic [Z_W-1:0] ATAN_TAB [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Per-point control that travels with the segment through the pipeline.
  typedef struct packed {
    logic             has_prev;
    logic             eval;
    logic             last;
    logic [IDX_W-1:0] node;
  } pscs_ctl_t;

  typedef struct packed {
    logic               split_here;
    logic [NODE_W-1:0]  split_node;
    logic [ANGLE_W-1:0] turn_angle;
  } pscs_res_t;

  // Position of the highest set bit; zero for a zero word.
  function automatic logic [MSB_W-1:0] msb_index(input logic [MAG_W-1:0] v);
    logic [MSB_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (v[i]) pos = MSB_W'(i);
    end
    return pos;
  endfunction

endpackage

// File: rtl/pscs_if.sv
interface pscs_point_if import pscs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic [CE_W-1:0]           circular_error;
  logic                      final_point;

  modport source(output valid, point_x, point_y, circular_error, final_point, input ready);
  modport sink(input valid, point_x, point_y, circular_error, final_point, output ready);
endinterface

interface pscs_split_if import pscs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               split_here;
  logic [NODE_W-1:0]  split_node;
  logic [ANGLE_W-1:0] turn_angle;

  modport source(output valid, split_here, split_node, turn_angle, input ready);
  modport sink(input valid, split_here, split_node, turn_angle, output ready);
endinterface

// File: rtl/polyline_sharp_corner_splitter.sv
// Sharp-corner splitter for a stream of polyline points. Each accepted point word closes a
// segment from the previous point; the segment heading comes from a fully pipelined CORDIC
// (one rotation per stage) as a 16-bit binary angle, and the turn at the previous node is
// compared against corner_threshold (32768 means pi, reset 8192). Next to the start of the
// current piece and next to the line end, a split also needs the adjoining segment to be longer
// than circular_error. Every point word yields exactly one split word, in order. The block
// takes one point word per clock while its input is ready; a word's result reaches the
// output through the difference, fold and normalize stages, the rotation pipeline and the
// rounding stage. Results wait in a 32-word queue, and the input is ready whenever fewer
// than 32 words are in flight, so a slow consumer stalls the input only once that queue is
// spoken for. The threshold register sits at byte address 0 of the APB port; reads return
// it, writes take effect at the access cycle.
module polyline_sharp_corner_splitter import pscs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  pscs_point_if.sink            points,
  pscs_split_if.source          splits,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // ---------------------------------------------------------------------------
  // Configuration register.
  // ---------------------------------------------------------------------------
  logic [THR_W-1:0] corner_threshold;
  logic             reg_hit;

  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_CORNER_THRESHOLD);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? APB_DATA_W'(corner_threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_threshold <= THR_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      corner_threshold <= pwdata[THR_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. Every accepted word is counted until its result is taken;
  // the queue is as deep as the count allows, so a result never finds it full
  // and the pipeline itself never stalls.
  // ---------------------------------------------------------------------------
  logic             accept, pop;
  logic [FIFO_AW:0] inflight;

  assign points.ready = !inflight[FIFO_AW];
  assign accept       = points.valid && points.ready;
  assign pop          = splits.valid && splits.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + (FIFO_AW + 1)'(accept) - (FIFO_AW + 1)'(pop);
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage: segment vector against the held point, and the index of the
  // node that this point makes testable. point_count saturates so that an
  // overlong line stops evaluating nodes until its final point.
  // ---------------------------------------------------------------------------
  logic signed [COORD_W-1:0] held_x, held_y;
  logic [CNT_W-1:0]          point_count;
  logic                      d_valid;
  logic signed [DIFF_W-1:0]  dx, dy;
  logic [CE_W-1:0]           ce;
  pscs_ctl_t                 ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_x      <= '0;
      held_y      <= '0;
      point_count <= '0;
      d_valid     <= 1'b0;
    end else begin
      d_valid <= accept;
      if (accept) begin
        held_x <= points.point_x;
        held_y <= points.point_y;
        if (points.final_point) begin
          point_count <= '0;
        end else if (point_count < CNT_W'(MAX_POINTS)) begin
          point_count <= point_count + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dx           <= DIFF_W'(points.point_x) - DIFF_W'(held_x);
      dy           <= DIFF_W'(points.point_y) - DIFF_W'(held_y);
      ce           <= points.circular_error;
      ctl.has_prev <= (point_count != '0);
      ctl.eval     <= (point_count >= CNT_W'(2)) && (point_count < CNT_W'(MAX_POINTS));
      ctl.last     <= points.final_point;
      ctl.node     <= IDX_W'(point_count - CNT_W'(1));
    end
  end

  // ---------------------------------------------------------------------------
  // Heading and length of each segment.
  // ---------------------------------------------------------------------------
  logic               seg_valid;
  logic [ANGLE_W-1:0] seg_heading;
  logic               seg_long;
  pscs_ctl_t          seg_ctl;

  pscs_segment u_segment (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d_valid),
    .dx       (dx),
    .dy       (dy),
    .ce       (ce),
    .in_ctl   (ctl),
    .out_valid(seg_valid),
    .heading  (seg_heading),
    .seg_long (seg_long),
    .out_ctl  (seg_ctl)
  );

  // ---------------------------------------------------------------------------
  // Corner decision. Segments arrive here in point order, so the heading and
  // length flag of the previous segment and the current piece start live here.
  // ---------------------------------------------------------------------------
  logic [ANGLE_W-1:0] held_heading, held_heading_next;
  logic               held_segment_long, held_segment_long_next;
  logic [IDX_W-1:0]   piece_start, piece_start_next;
  logic [ANGLE_W-1:0] head_diff, turn;
  logic               next_to_start;
  logic               ok;
  pscs_res_t          res;

  assign head_diff     = seg_heading - held_heading;
  assign turn          = (head_diff > HALF_TURN) ? -head_diff : head_diff;
  assign next_to_start = ({1'b0, seg_ctl.node} == ({1'b0, piece_start} + (IDX_W + 1)'(1)));

  always_comb begin
    held_heading_next      = held_heading;
    held_segment_long_next = held_segment_long;
    piece_start_next       = piece_start;
    ok                     = 1'b0;
    res                    = '0;
    if (seg_valid) begin
      if (seg_ctl.has_prev) begin
        if (seg_ctl.eval && (seg_ctl.node > piece_start)) begin
          ok = turn > corner_threshold;
          // Short segment next to the piece start or at the line end.
          if (next_to_start && !held_segment_long) ok = 1'b0;
          if (seg_ctl.last && !seg_long) ok = 1'b0;
          if (ok) begin
            res.split_here   = 1'b1;
            res.split_node   = NODE_W'(seg_ctl.node);
            res.turn_angle   = turn;
            piece_start_next = seg_ctl.node;
          end
        end
        held_heading_next      = seg_heading;
        held_segment_long_next = seg_long;
      end
      if (seg_ctl.last) piece_start_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_heading      <= '0;
      held_segment_long <= 1'b0;
      piece_start       <= '0;
    end else begin
      held_heading      <= held_heading_next;
      held_segment_long <= held_segment_long_next;
      piece_start       <= piece_start_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue.
  // ---------------------------------------------------------------------------
  pscs_res_t head;

  pscs_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (seg_valid),
    .wr_data  (res),
    .rd_en    (pop),
    .rd_data  (head),
    .not_empty(splits.valid)
  );

  assign splits.split_here = head.split_here;
  assign splits.split_node = head.split_node;
  assign splits.turn_angle = head.turn_angle;

endmodule

// File: rtl/pscs_segment.sv
module pscs_segment import pscs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic signed [DIFF_W-1:0] dx,
  input  logic signed [DIFF_W-1:0] dy,
  input  logic [CE_W-1:0]          ce,
  input  pscs_ctl_t                in_ctl,
  output logic                     out_valid,
  output logic [ANGLE_W-1:0]       heading,
  output logic                     seg_long,
  output pscs_ctl_t                out_ctl
);

  // Stage A: fold into the right half plane, magnitudes, error squared.
  logic                     va;
  logic signed [DIFF_W-1:0] xa, ya;
  logic [Z_W-1:0]           za;
  logic                     zero_a;
  logic [MAG_W-1:0]         mx_a, my_a;
  logic [CESQ_W-1:0]        cesq_a;
  pscs_ctl_t                ctl_a;

  // Stage B: normalizing shift amount and partial squares.
  logic                     vb;
  logic signed [DIFF_W-1:0] xb, yb;
  logic [Z_W-1:0]           zb;
  logic                     zero_b;
  logic [SHIFT_W-1:0]       kb;
  logic [MAG_W-1:0]         xhh, xhl, xll, yhh, yhl, yll;
  logic [CESQ_W-1:0]        cesq_b;
  pscs_ctl_t                ctl_b;

  // Stage C feeds the rotation chain at index 0.
  logic                     cv    [CORDIC_STEPS+1];
  logic signed [CW-1:0]     cx    [CORDIC_STEPS+1];
  logic signed [CW-1:0]     cy    [CORDIC_STEPS+1];
  logic [Z_W-1:0]           cz    [CORDIC_STEPS+1];
  logic                     czero [CORDIC_STEPS+1];
  pscs_ctl_t                cctl  [CORDIC_STEPS+1];
  logic                     clong [CORDIC_STEPS+1];
  logic [SQ_W-1:0]          sqx_c, sqy_c;
  logic [CESQ_W-1:0]        cesq_c;

  logic [MAG_W-1:0]         mmax;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= in_valid;
    end
    xa     <= dx[DIFF_W-1] ? -dx : dx;
    ya     <= dx[DIFF_W-1] ? -dy : dy;
    za     <= dx[DIFF_W-1] ? Z_HALF_TURN : '0;
    zero_a <= (dx == '0) && (dy == '0);
    mx_a   <= MAG_W'(dx[DIFF_W-1] ? -dx : dx);
    my_a   <= MAG_W'(dy[DIFF_W-1] ? -dy : dy);
    cesq_a <= CESQ_W'(ce) * CESQ_W'(ce);
    ctl_a  <= in_ctl;
  end

  assign mmax = (mx_a > my_a) ? mx_a : my_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    xb     <= xa;
    yb     <= ya;
    zb     <= za;
    zero_b <= zero_a;
    kb     <= SHIFT_W'(NORM_BIT) - SHIFT_W'(msb_index(mmax));
    xhh    <= MAG_W'(mx_a[MAG_W-1:HALF_W]) * MAG_W'(mx_a[MAG_W-1:HALF_W]);
    xhl    <= MAG_W'(mx_a[MAG_W-1:HALF_W]) * MAG_W'(mx_a[HALF_W-1:0]);
    xll    <= MAG_W'(mx_a[HALF_W-1:0]) * MAG_W'(mx_a[HALF_W-1:0]);
    yhh    <= MAG_W'(my_a[MAG_W-1:HALF_W]) * MAG_W'(my_a[MAG_W-1:HALF_W]);
    yhl    <= MAG_W'(my_a[MAG_W-1:HALF_W]) * MAG_W'(my_a[HALF_W-1:0]);
    yll    <= MAG_W'(my_a[HALF_W-1:0]) * MAG_W'(my_a[HALF_W-1:0]);
    cesq_b <= cesq_a;
    ctl_b  <= ctl_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else begin
      cv[0] <= vb;
    end
    cx[0]    <= CW'(xb) <<< kb;
    cy[0]    <= CW'(yb) <<< kb;
    cz[0]    <= zb;
    czero[0] <= zero_b;
    cctl[0]  <= ctl_b;
    sqx_c    <= {xhh, {MAG_W{1'b0}}} + SQ_W'({xhl, {(HALF_W + 1){1'b0}}}) + SQ_W'(xll);
    sqy_c    <= {yhh, {MAG_W{1'b0}}} + SQ_W'({yhl, {(HALF_W + 1){1'b0}}}) + SQ_W'(yll);
    cesq_c   <= cesq_b;
  end

  // The length test rides in parallel with the first rotation.
  assign clong[0] = 1'b0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [CW-1:0] xs, ys;
    logic                 up;

    assign xs = cx[i] >>> i;
    assign ys = cy[i] >>> i;
    assign up = !cy[i][CW-1] && (cy[i] != '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else begin
        cv[i+1] <= cv[i];
      end
      cx[i+1]    <= up ? cx[i] + ys : cx[i] - ys;
      cy[i+1]    <= up ? cy[i] - xs : cy[i] + xs;
      cz[i+1]    <= up ? cz[i] + ATAN_TAB[i] : cz[i] - ATAN_TAB[i];
      czero[i+1] <= czero[i];
      cctl[i+1]  <= cctl[i];
      if (i == 0) begin
        clong[i+1] <= ({1'b0, sqx_c} + {1'b0, sqy_c}) > (SQ_W + 1)'(cesq_c);
      end else begin
        clong[i+1] <= clong[i];
      end
    end
  end

  logic [Z_W-1:0] z_round;

  assign z_round = cz[CORDIC_STEPS] + ROUND_BIAS;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cv[CORDIC_STEPS];
    end
    heading  <= czero[CORDIC_STEPS] ? '0 : z_round[Z_W-1 -: ANGLE_W];
    seg_long <= clong[CORDIC_STEPS];
    out_ctl  <= cctl[CORDIC_STEPS];
  end

endmodule

// File: rtl/pscs_fifo.sv
module pscs_fifo import pscs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  pscs_res_t wr_data,
  input  logic      rd_en,
  output pscs_res_t rd_data,
  output logic      not_empty
);

  localparam int DEPTH = 2 ** FIFO_AW;

  pscs_res_t          mem [DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   count;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + FIFO_AW'(1);
      if (rd_en) rd_ptr <= rd_ptr + FIFO_AW'(1);
      count <= count + (FIFO_AW + 1)'(wr_en) - (FIFO_AW + 1)'(rd_en);
    end
  end

  assign rd_data   = mem[rd_ptr];
  assign not_empty = (count != '0);

endmodule

// File: rtl/pscs_checker.sv
module pscs_checker import pscs_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               split_here,
  input logic [NODE_W-1:0]  split_node,
  input logic [ANGLE_W-1:0] turn_angle
);

  logic [15:0] outstanding;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 16'(in_valid && in_ready) - 16'(out_valid && out_ready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({split_here, split_node, turn_angle}))
    else $error("split word changed while stalled");

  a_no_split_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !split_here |-> split_node == '0 && turn_angle == '0)
    else $error("non-split word carries node or angle");

  a_split_angle: assert property (@(posedge clk) disable iff (rst)
    out_valid && split_here |-> turn_angle != '0 && turn_angle <= HALF_TURN)
    else $error("split turn angle out of range");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> outstanding != '0)
    else $error("split word without an accepted point word");

endmodule

bind polyline_sharp_corner_splitter pscs_checker u_pscs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (points.valid),
  .in_ready  (points.ready),
  .out_valid (splits.valid),
  .out_ready (splits.ready),
  .split_here(splits.split_here),
  .split_node(splits.split_node),
  .turn_angle(splits.turn_angle)
);

// File: tb/sv/tb_polyline_sharp_corner_splitter.sv
module tb_polyline_sharp_corner_splitter;
  timeunit 1ns;
  timeprecision 1ps;

  import pscs_pkg::*;

  // A run of this many cycles with no word moving on either channel means the
  // block has hung. The longest legal quiet stretch is the deliberate output
  // hold-off plus the pipeline depth, which is far below this.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;

  // One point word as the testbench queues and predicts it.
  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [CE_W-1:0]           ce;
    logic                      last;
  } point_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  pscs_point_if points_bus ();
  pscs_split_if splits_bus ();

  polyline_sharp_corner_splitter dut (
    .clk     (clk),
    .rst     (rst),
    .points  (points_bus),
    .splits  (splits_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // Words waiting to be offered, and split words the block still owes us.
  point_word_t pending_points[$];
  pscs_res_t   expected_splits[$];

  // Our own copy of the splitter state and of the threshold register.
  logic [THR_W-1:0]   threshold_now;
  longint             prev_x;
  longint             prev_y;
  logic [ANGLE_W-1:0] prev_heading;
  logic               prev_long;
  int unsigned        line_count;
  int unsigned        piece_begin;

  int  error_count;
  int  points_accepted;
  int  splits_checked;
  int  corners_split;
  int  quiet_cycles;
  int  random_threshold;

  // Handshake bookkeeping of the clocked processes; point_taken passes from the monitor to the point driver.
  bit  point_taken;
  bit  idle_allowed;
  bit  hold_request;
  int  hold_left;
  int  in_gap;
  int  out_gap;
  int  in_stretch;
  int  out_stretch;
  bit  in_bursty;
  bit  out_bursty;

  // Heading of a segment as a 16-bit binary angle. The vector is folded into
  // the right half plane, scaled up so its larger component reaches bit 40,
  // and then rotated toward the x axis one CORDIC step at a time while the
  // angle accumulates at 32 bits per turn. The 32-bit angle is rounded half
  // up to 16 bits, wrapping at a full turn.
  function automatic logic [ANGLE_W-1:0] segment_heading(longint dx, longint dy);
    longint            cx;
    longint            cy;
    longint            xs;
    longint            ys;
    longint unsigned   ax;
    longint unsigned   ay;
    longint unsigned   span;
    int                sh;
    logic [Z_W-1:0]    z;
    logic [Z_W-1:0]    zr;
    if (dx == 0 && dy == 0) return '0;
    cx = dx;
    cy = dy;
    z = '0;
    if (cx < 0) begin
      cx = -cx;
      cy = -cy;
      z = Z_HALF_TURN;
    end
    ax = cx;
    ay = (cy < 0) ? -cy : cy;
    span = (ax > ay) ? ax : ay;
    sh = 0;
    while (span < (64'd1 << NORM_BIT)) begin
      span = span << 1;
      sh++;
    end
    cx = cx <<< sh;
    cy = cy <<< sh;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (cy > 0) begin
        cx = cx + ys;
        cy = cy - xs;
        z = z + ATAN_TAB[i];
      end else begin
        cx = cx - ys;
        cy = cy + xs;
        z = z - ATAN_TAB[i];
      end
    end
    zr = z + ROUND_BIAS;
    return zr[31:16];
  endfunction

  // True when the segment is longer than the error radius. Squares are
  // compared, and a sum that overflows 64 bits is always long enough.
  function automatic logic segment_long(longint dx, longint dy, logic [CE_W-1:0] ce);
    logic [63:0] ax;
    logic [63:0] ay;
    logic [65:0] sq;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    sq = {2'b00, ax * ax} + {2'b00, ay * ay};
    if (sq[65:64] != 2'b00) return 1'b1;
    return sq[63:0] > (64'(ce) * 64'(ce));
  endfunction

  // Advances our copy of the splitter by one accepted point word and returns
  // the split word that this point must produce.
  function automatic pscs_res_t next_split_word(point_word_t p);
    pscs_res_t          res;
    longint             dx;
    longint             dy;
    logic [ANGLE_W-1:0] h;
    logic [ANGLE_W-1:0] diff;
    logic               seg_long;
    logic               ok;
    int unsigned        j;
    int unsigned        turn;
    res = '0;
    if (line_count > 0) begin
      dx = longint'(p.x) - prev_x;
      dy = longint'(p.y) - prev_y;
      h = segment_heading(dx, dy);
      seg_long = segment_long(dx, dy, p.ce);
      // Only interior nodes of the current piece are judged, and nothing is
      // judged once the point counter has saturated.
      if (line_count >= 2 && line_count < MAX_POINTS) begin
        j = line_count - 1;
        if (j > piece_begin) begin
          diff = h - prev_heading;
          turn = 32'(diff);
          if (turn > 32768) turn = 65536 - turn;
          ok = turn > threshold_now;
          if (j == piece_begin + 1 && !prev_long) ok = 1'b0;
          if (p.last && !seg_long) ok = 1'b0;
          if (ok) begin
            res.split_here = 1'b1;
            res.split_node = j[NODE_W-1:0];
            res.turn_angle = turn[ANGLE_W-1:0];
            piece_begin = j;
          end
        end
      end
      prev_heading = h;
      prev_long = seg_long;
    end
    prev_x = p.x;
    prev_y = p.y;
    if (line_count < MAX_POINTS) line_count++;
    if (p.last) begin
      line_count = 0;
      piece_begin = 0;
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endfunction

  task automatic add_point(input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
                           input logic [CE_W-1:0] ce, input logic last);
    point_word_t w;
    w.x = x;
    w.y = y;
    w.ce = ce;
    w.last = last;
    pending_points = {pending_points, w};
  endtask

  // Queues one polyline. Most lines are well formed: a walk at one random
  // scale with straight runs, repeated points and sharp turns, and an error
  // radius close to the step length so the length rule cuts both ways. The
  // rest are noise lines of full-range coordinates and per-point radii.
  task automatic queue_random_line();
    int                        n;
    int                        scale;
    int                        pick;
    int                        sx;
    int                        sy;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [CE_W-1:0]           ce;
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
    if ($urandom_range(0, 7) == 0) begin
      for (int i = 0; i < n; i++)
        add_point($urandom, $urandom, CE_W'($urandom), i == n - 1);
    end else begin
      scale = $urandom_range(0, 24);
      x = $signed($urandom) >>> 2;
      y = $signed($urandom) >>> 2;
      case ($urandom_range(0, 3))
        0: ce = '0;
        1: ce = CE_W'($urandom_range(0, 3 << scale));
        2: ce = CE_W'($urandom_range(0, 1 << scale));
        default: ce = CE_W'($urandom);
      endcase
      sx = 1 << scale;
      sy = 0;
      for (int i = 0; i < n; i++) begin
        pick = $urandom_range(0, 9);
        if (i > 0 && pick == 0) begin
          // Repeated point: a zero-length segment.
        end else if (i > 0 && pick < 4) begin
          x = x + sx;
          y = y + sy;
        end else if (i > 0) begin
          sx = int'($urandom_range(0, 2 << scale)) - (1 << scale);
          sy = int'($urandom_range(0, 2 << scale)) - (1 << scale);
          x = x + sx;
          y = y + sy;
        end
        add_point(x, y, ce, i == n - 1);
      end
    end
  endtask

  task automatic queue_random_points(input int target);
    int start;
    start = pending_points.size();
    while (pending_points.size() - start < target) queue_random_line();
  endtask

  // Waits until every queued word has been taken and every split word has
  // come back; the block is then idle since each point yields one word. The
  // check runs just after the falling edge so that a word the driver puts up
  // at that edge is already visible.
  task automatic wait_drained();
    do begin
      @(negedge clk);
      #1;
    end while (pending_points.size() != 0 || points_bus.valid || expected_splits.size() != 0);
  endtask

  // APB write of the threshold register: a setup cycle, then an access cycle
  // that completes at the first rising edge with pready high.
  task automatic write_threshold(input logic [THR_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_CORNER_THRESHOLD, 2'b00};
    pwdata <= APB_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    threshold_now = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Point driver. A new word is put up at the falling edge once the previous
  // one was taken, sometimes after a short gap. Gaps only come in bursty
  // stretches, so there are also long runs at full rate.
  always @(negedge clk) begin : drive_points
    point_word_t w;
    if (in_stretch == 0) begin
      in_stretch = $urandom_range(16, 160);
      in_bursty = $urandom_range(0, 2) != 0;
    end else begin
      in_stretch--;
    end
    if (rst) begin
      points_bus.valid <= 1'b0;
    end else if (!points_bus.valid || point_taken) begin
      point_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        points_bus.valid <= 1'b0;
      end else if (pending_points.size() != 0) begin
        w = pending_points.pop_front();
        points_bus.point_x <= w.x;
        points_bus.point_y <= w.y;
        points_bus.circular_error <= w.ce;
        points_bus.final_point <= w.last;
        points_bus.valid <= 1'b1;
        if (idle_allowed && in_bursty && $urandom_range(0, 4) == 0)
          in_gap = $urandom_range(1, 6);
      end else begin
        points_bus.valid <= 1'b0;
      end
    end
  end

  // Split word receiver. Besides the random stall bursts, a requested
  // hold-off keeps ready low for a long stretch so that the result queue
  // fills and the block has to stall its point input.
  always @(negedge clk) begin : drive_ready
    if (out_stretch == 0) begin
      out_stretch = $urandom_range(16, 160);
      out_bursty = $urandom_range(0, 2) != 0;
    end else begin
      out_stretch--;
    end
    if (rst) begin
      splits_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      splits_bus.ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
      splits_bus.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      splits_bus.ready <= 1'b0;
    end else begin
      splits_bus.ready <= 1'b1;
      if (idle_allowed && out_bursty && $urandom_range(0, 4) == 0)
        out_gap = $urandom_range(1, 6);
    end
  end

  // Monitor. Everything is sampled at the rising edge: an accepted point word
  // advances the prediction, an accepted split word is checked against the
  // oldest prediction, and the watchdog watches for a channel that hangs.
  always @(posedge clk) begin : watch_channels
    point_word_t taken;
    pscs_res_t   want;
    bit          moved;
    if (!rst) begin
      moved = 1'b0;
      if (points_bus.valid && points_bus.ready) begin
        taken.x = points_bus.point_x;
        taken.y = points_bus.point_y;
        taken.ce = points_bus.circular_error;
        taken.last = points_bus.final_point;
        want = next_split_word(taken);
        expected_splits = {expected_splits, want};
        point_taken = 1'b1;
        points_accepted++;
        moved = 1'b1;
      end
      if (splits_bus.valid && splits_bus.ready) begin
        moved = 1'b1;
        if (expected_splits.size() == 0) begin
          error_count++;
          $error("split word with no point word outstanding: split_here %0d node %0d turn %0d",
                 splits_bus.split_here, splits_bus.split_node, splits_bus.turn_angle);
        end else begin
          want = expected_splits.pop_front();
          check_field("split_here", 32'(want.split_here), 32'(splits_bus.split_here));
          check_field("split_node", 32'(want.split_node), 32'(splits_bus.split_node));
          check_field("turn_angle", 32'(want.turn_angle), 32'(splits_bus.turn_angle));
          if (want.split_here) corners_split++;
          splits_checked++;
        end
      end
      if (moved || psel) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no word moved for %0d cycles, %0d split words still owed",
                   quiet_cycles, expected_splits.size());
          $display("tb_polyline_sharp_corner_splitter: errors");
          $finish;
        end
      end
    end
  end

  initial begin
    points_bus.valid = 1'b0;
    points_bus.point_x = '0;
    points_bus.point_y = '0;
    points_bus.circular_error = '0;
    points_bus.final_point = 1'b0;
    splits_bus.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    threshold_now = THR_RESET;
    prev_x = 0;
    prev_y = 0;
    prev_heading = '0;
    prev_long = 1'b0;
    line_count = 0;
    piece_begin = 0;
    idle_allowed = 1'b1;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed lines at the reset threshold. A lone point, and a two-point
    // line, which can never split.
    add_point(7, -3, 0, 1'b1);
    add_point(0, 0, 5, 1'b0);
    add_point(-100, 50, 5, 1'b1);
    // A square: right-angle corners with long segments split at both nodes,
    // the second one also next to the line end.
    add_point(0, 0, 10, 1'b0);
    add_point(1000, 0, 10, 1'b0);
    add_point(1000, 1000, 10, 1'b0);
    add_point(0, 1000, 10, 1'b1);
    // A sharp corner refused because the segment next to the piece start is
    // within the error radius; the corner at the long last segment splits.
    add_point(0, 0, 100, 1'b0);
    add_point(5, 0, 100, 1'b0);
    add_point(5, 5, 100, 1'b0);
    add_point(500, 5, 100, 1'b1);
    // A repeated point: the zero-length segment has heading zero.
    add_point(0, 0, 0, 1'b0);
    add_point(100, 0, 0, 1'b0);
    add_point(100, 0, 0, 1'b0);
    add_point(100, 100, 0, 1'b1);
    // Doubling back: a turn of exactly half a circle.
    add_point(0, 0, 0, 1'b0);
    add_point(100, 0, 0, 1'b0);
    add_point(0, 0, 0, 1'b1);
    // Coordinate extremes and the largest radius; the diagonal jump makes
    // the sum of squares overflow 64 bits.
    add_point(32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF, 1'b0);
    add_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
    add_point(32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
    add_point(32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 1'b0);
    add_point(0, 0, 31'h7FFF_FFFF, 1'b1);
    wait_drained();

    // Random lines at the reset threshold, with one long output hold-off
    // while the point driver keeps offering words.
    @(posedge clk);
    queue_random_points(400);
    hold_request = 1'b1;
    wait_drained();

    // Threshold at zero: every nonzero turn that passes the length rule.
    write_threshold(16'd0);
    @(posedge clk);
    queue_random_points(250);
    wait_drained();

    // Threshold at half a turn: nothing can split.
    write_threshold(HALF_TURN);
    @(posedge clk);
    queue_random_points(150);
    wait_drained();

    write_threshold(16'd16384);
    @(posedge clk);
    queue_random_points(200);
    wait_drained();

    // Last part at a random threshold, with both sides at full rate.
    random_threshold = $urandom_range(1, 32767);
    write_threshold(THR_W'(random_threshold));
    idle_allowed = 1'b0;
    @(posedge clk);
    queue_random_points(200);
    wait_drained();

    // Give a stray extra word time to show up before the verdict.
    repeat (PIPE_LATENCY + 10) @(posedge clk);

    $display("summary: %0d point words in, %0d split words checked, %0d of them splits",
             points_accepted, splits_checked, corners_split);
    $display("summary: thresholds 8192, 0, 32768, 16384 and %0d, with one long output stall",
             random_threshold);
    if (error_count == 0 && expected_splits.size() == 0) begin
      $display("tb_polyline_sharp_corner_splitter: clean");
    end else begin
      $display("tb_polyline_sharp_corner_splitter: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/pscs_pkg.sv
rtl/pscs_if.sv
rtl/pscs_segment.sv
rtl/pscs_fifo.sv
rtl/polyline_sharp_corner_splitter.sv
rtl/pscs_checker.sv
tb/sv/tb_polyline_sharp_corner_splitter.sv
